>>> rtl/core/open_addressing_hash_table_unit_defines.svh
// Assertion macros for the open-addressing hash table unit.
// Used by the top level; expects clk_i and rst_ni in the scope of each use.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/oaht_pkg.sv
// Shared constants for the open-addressing hash table unit.
// No dependencies.
`timescale 1ns / 1ps

package oaht_pkg;

  localparam int NumW    = 9;   // width of the table size register
  localparam int KeyW    = 31;
  localparam int KeyIdxW = 5;   // bit index into a key
  localparam int FuncW   = 2;
  localparam int StatusW = 2;
  localparam int SlotW   = 8;

  localparam logic [FuncW-1:0] FuncInsert = 2'd0;
  localparam logic [FuncW-1:0] FuncRemove = 2'd1;
  localparam logic [FuncW-1:0] FuncLookup = 2'd2;

  localparam logic [StatusW-1:0] StatusDone   = 2'd0;
  localparam logic [StatusW-1:0] StatusAbsent = 2'd1;
  localparam logic [StatusW-1:0] StatusFull   = 2'd2;

  localparam logic [NumW-1:0] TableSizeReset = 9'd256;

endpackage

>>> rtl/core/open_addressing_hash_table_unit.sv
// An accepted item computes its home slot, one remainder bit per cycle (StMod), then
// probes slot by slot, each probe a RAM read (StRead) and then a compare (StCmp), up to
// the effective size in probes, and loads the result (StRes), waiting for the output
// register. One item at a time. After reset a clearing pass over min(MAX_SLOTS, 511)
// slots empties the slot RAM; no item is accepted meanwhile. Configuration at any time.
// Depends on oaht_pkg, oaht_ram and open_addressing_hash_table_unit_defines.svh.
`timescale 1ns / 1ps
`include "open_addressing_hash_table_unit_defines.svh"

module open_addressing_hash_table_unit #(
  parameter int MAX_SLOTS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [oaht_pkg::NumW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [oaht_pkg::FuncW-1:0]   func_i,
  input  logic [oaht_pkg::KeyW-1:0]    key_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [oaht_pkg::StatusW-1:0] status_o,
  output logic [oaht_pkg::SlotW-1:0]   slot_o
);

  localparam int NumW   = oaht_pkg::NumW;
  localparam int KeyW   = oaht_pkg::KeyW;
  localparam int MaxNum = (1 << NumW) - 1;
  // Slots beyond what the size register can reach are never used.
  localparam int Depth  = (MAX_SLOTS < MaxNum) ? MAX_SLOTS : MaxNum;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WordW  = KeyW + 1;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StMod   = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StCmp   = 3'd4;
  localparam logic [2:0] StRes   = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [NumW-1:0]              tsize_q;
  logic [NumW-1:0]              num;
  logic [oaht_pkg::FuncW-1:0]   func_q, func_d;
  logic [KeyW-1:0]              key_q, key_d;
  logic [NumW-1:0]              rem_q, rem_d;
  logic [NumW-1:0]              cnt_q, cnt_d;
  logic [AW-1:0]                pos_q, pos_d;
  logic [oaht_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic [AW-1:0]                res_slot_q, res_slot_d;
  logic                         out_valid_q, out_valid_d;
  logic [oaht_pkg::StatusW-1:0] status_q, status_d;
  logic [oaht_pkg::SlotW-1:0]   slot_q, slot_d;

  logic [NumW:0]  trial;
  logic [NumW:0]  pos_inc;
  logic           ram_we, ram_re;
  logic [WordW-1:0] ram_wdata, ram_rdata;
  logic           hit_valid;
  logic [KeyW-1:0] hit_key;

  // Effective size: zero reads as one, anything above the table saturates.
  always_comb begin
    if (tsize_q == '0) begin
      num = NumW'(1);
    end else if (tsize_q > NumW'(Depth)) begin
      num = NumW'(Depth);
    end else begin
      num = tsize_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= oaht_pkg::TableSizeReset;
    end else if (cfg_valid_i) begin
      tsize_q <= cfg_data_i;
    end
  end

  // Remainder step: shift in one key bit; StMod subtracts the size if it fits.
  assign trial   = {rem_q, key_q[cnt_q[oaht_pkg::KeyIdxW-1:0]]};
  assign pos_inc = (NumW + 1)'(pos_q) + (NumW + 1)'(1);

  assign hit_valid = ram_rdata[WordW-1];
  assign hit_key   = ram_rdata[KeyW-1:0];

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    key_d        = key_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    slot_d       = slot_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wdata    = {1'b0, key_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (pos_q == AW'(Depth - 1)) begin
          pos_d   = '0;
          state_d = StIdle;
        end else begin
          pos_d = pos_q + AW'(1);
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          func_d  = func_i;
          key_d   = key_id_i;
          rem_d   = '0;
          cnt_d   = NumW'(KeyW - 1);
          state_d = StMod;
        end
      end
      StMod: begin
        if (trial >= {1'b0, num}) begin
          rem_d = NumW'(trial - {1'b0, num});
        end else begin
          rem_d = trial[NumW-1:0];
        end
        if (cnt_q == '0) begin
          pos_d   = AW'(rem_d);
          state_d = StRead;
        end else begin
          cnt_d = cnt_q - NumW'(1);
        end
      end
      StRead: begin
        ram_re  = 1'b1;
        state_d = StCmp;
      end
      StCmp: begin
        if (!hit_valid) begin
          if (func_q == oaht_pkg::FuncInsert) begin
            ram_we       = 1'b1;
            ram_wdata    = {1'b1, key_q};
            res_status_d = oaht_pkg::StatusDone;
          end else begin
            res_status_d = oaht_pkg::StatusAbsent;
          end
          res_slot_d = pos_q;
          state_d    = StRes;
        end else if (hit_key == key_q) begin
          // A remove hit empties the slot; an insert hit leaves it as it is.
          if (func_q == oaht_pkg::FuncRemove) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, key_q};
          end
          res_status_d = oaht_pkg::StatusDone;
          res_slot_d   = pos_q;
          state_d      = StRes;
        end else if (cnt_q + NumW'(1) == num) begin
          res_status_d = oaht_pkg::StatusFull;
          res_slot_d   = '0;
          state_d      = StRes;
        end else begin
          cnt_d   = cnt_q + NumW'(1);
          pos_d   = (pos_inc >= {1'b0, num}) ? '0 : AW'(pos_inc);
          state_d = StRead;
        end
      end
      StRes: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          slot_d      = oaht_pkg::SlotW'(res_slot_q);
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      pos_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
  end

  oaht_ram #(
    .WIDTH(WordW),
    .DEPTH(Depth)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

  `OAHT_ASSERT_NEXT(a_accept_starts_mod, in_valid_i && in_ready_o, state_q == StMod,
                    "accepted item did not start the remainder")
  `OAHT_ASSERT_NOW(a_cmp_after_read, state_q == StCmp, $past(state_q) == StRead,
                   "compare without a preceding RAM read")
  `OAHT_ASSERT_NOW(a_probe_count_bound, state_q == StRead, cnt_q < num,
                   "probe count reached the table size")
  `OAHT_ASSERT_NOW(a_full_slot_zero, out_valid_o && status_o == oaht_pkg::StatusFull,
                   slot_o == '0, "full table result with non-zero slot")

endmodule

>>> rtl/core/oaht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/open_addressing_hash_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for open_addressing_hash_table_unit: directed and random insert,
// remove and lookup transfers over several table sizes, each result checked against a
// behavioural copy of the probe walk. Depends on oaht_pkg and the unit's RTL.

module open_addressing_hash_table_unit_tb;

  localparam int MaxSlots    = 256;
  localparam int IdleLimit   = 4000;  // clearing pass plus a full-circle probe, many times over
  localparam int DrainCycles = 600;   // longest probe of a 256-slot table
  localparam int MaxReports  = 10;

  // The spare function code is handled as a lookup by the block.
  localparam logic [oaht_pkg::FuncW-1:0] FuncSpare = 2'd3;

  typedef struct packed {
    logic [oaht_pkg::StatusW-1:0] status;
    logic [oaht_pkg::SlotW-1:0]   slot;
  } probe_result_t;

  typedef enum logic [1:0] {RxAlways, RxCoin, RxSparse, RxBlocked} rx_mode_e;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [oaht_pkg::NumW-1:0]    cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic [oaht_pkg::FuncW-1:0]   func      = oaht_pkg::FuncLookup;
  logic [oaht_pkg::KeyW-1:0]    key_id    = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [oaht_pkg::StatusW-1:0] status;
  logic [oaht_pkg::SlotW-1:0]   slot;

  // Behavioural copy of the slot store and the size register.
  logic                         slot_used  [MaxSlots];
  logic [oaht_pkg::KeyW-1:0]    slot_key_q [MaxSlots];
  logic [oaht_pkg::NumW-1:0]    table_size_q;

  probe_result_t      expected_results [$];
  int                 error_count = 0;
  int                 burst_left  = 1;
  logic               in_held     = 1'b0;
  int                 idle_cycles = 0;
  rx_mode_e           rx_mode     = RxAlways;
  int                 rx_mode_left = 0;
  int unsigned        rx_cycle    = 0;

  always #1 clk = ~clk;

  open_addressing_hash_table_unit #(
    .MAX_SLOTS(MaxSlots)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .func_i     (func),
    .key_id_i   (key_id),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .status_o   (status),
    .slot_o     (slot)
  );

  // A size of zero behaves as one slot; anything above the store saturates.
  function automatic int unsigned effective_slots(input logic [oaht_pkg::NumW-1:0] size);
    int unsigned n;
    n = 32'(size);
    if (n == 0) n = 1;
    if (n > MaxSlots) n = MaxSlots;
    return n;
  endfunction

  // Walks the probe sequence for one operation, updates the store and returns the result.
  function automatic probe_result_t apply_table_op(input logic [oaht_pkg::FuncW-1:0] op,
                                                   input logic [oaht_pkg::KeyW-1:0] key);
    int unsigned   n;
    int unsigned   pos;
    logic          stopped;
    probe_result_t res;
    n          = effective_slots(table_size_q);
    pos        = {1'b0, key} % n;
    stopped    = 1'b0;
    res.status = oaht_pkg::StatusFull;
    res.slot   = '0;
    for (int unsigned i = 0; i < n && !stopped; i++) begin
      if (!slot_used[pos]) begin
        if (op == oaht_pkg::FuncInsert) begin
          slot_used[pos]  = 1'b1;
          slot_key_q[pos] = key;
          res.status      = oaht_pkg::StatusDone;
        end else begin
          res.status = oaht_pkg::StatusAbsent;
        end
        res.slot = pos[oaht_pkg::SlotW-1:0];
        stopped  = 1'b1;
      end else if (slot_key_q[pos] == key) begin
        if (op == oaht_pkg::FuncRemove) slot_used[pos] = 1'b0;
        res.status = oaht_pkg::StatusDone;
        res.slot   = pos[oaht_pkg::SlotW-1:0];
        stopped    = 1'b1;
      end else begin
        pos = (pos + 1 == n) ? 0 : pos + 1;
      end
    end
    return res;
  endfunction

  // Ends the current burst with a gap now and then; otherwise valid stays high.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      gap      = $urandom_range(1, 80);
      in_valid <= 1'b0;
      in_held  = 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
  endtask

  task automatic send_op(input logic [oaht_pkg::FuncW-1:0] op,
                         input logic [oaht_pkg::KeyW-1:0] key);
    in_valid <= 1'b1;
    func     <= op;
    key_id   <= key;
    in_held  = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_table_op(op, key));
    pace_sender();
  endtask

  task automatic wait_idle();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held  = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [oaht_pkg::NumW-1:0] size);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    table_size_q = size;
  endtask

  // Empty table at the reset size: misses, first inserts, rewrite, spare code, removal.
  task automatic test_basic_ops();
    send_op(oaht_pkg::FuncLookup, '0);
    send_op(oaht_pkg::FuncRemove, 31'd5);
    send_op(oaht_pkg::FuncInsert, '0);
    send_op(oaht_pkg::FuncInsert, '1);
    send_op(oaht_pkg::FuncInsert, '1);
    send_op(FuncSpare,  '1);
    send_op(oaht_pkg::FuncRemove, '0);
    send_op(oaht_pkg::FuncLookup, '0);
  endtask

  // Keys sharing a home slot, a probe wrapping past the last slot, and a hole left by a
  // removal that ends a later lookup early.
  task automatic test_collision_and_wrap();
    send_op(oaht_pkg::FuncInsert, 31'd256);
    send_op(oaht_pkg::FuncInsert, 31'd512);
    send_op(oaht_pkg::FuncInsert, 31'd511);
    send_op(oaht_pkg::FuncLookup, 31'd511);
    send_op(oaht_pkg::FuncRemove, 31'd512);
    send_op(oaht_pkg::FuncLookup, 31'd511);
  endtask

  // Size zero acts as one slot; an oversized value saturates. Entries are kept across both.
  task automatic test_size_extremes();
    write_table_size('0);
    send_op(oaht_pkg::FuncInsert, 31'd9);
    send_op(oaht_pkg::FuncLookup, 31'd256);
    write_table_size('1);
    send_op(oaht_pkg::FuncLookup, '1);
  endtask

  // Three slots filled so that a probe goes all the way round.
  task automatic test_full_circle();
    write_table_size(9'd3);
    send_op(oaht_pkg::FuncInsert, 31'd4);
    send_op(oaht_pkg::FuncInsert, 31'd10);
    send_op(oaht_pkg::FuncLookup, 31'd10);
    send_op(oaht_pkg::FuncRemove, 31'd4);
  endtask

  task automatic run_random_phase(input logic [oaht_pkg::NumW-1:0] size, input int items);
    int unsigned   n;
    int unsigned   pick;
    logic [oaht_pkg::KeyW-1:0] key_pool [$];
    logic [oaht_pkg::KeyW-1:0] key;
    logic [oaht_pkg::FuncW-1:0] op;
    write_table_size(size);
    n = effective_slots(size);
    // Half of the pool crowds into the first quarter of the homes to force long runs.
    repeat (n + n / 2 + 2) begin
      if ($urandom_range(0, 1) == 1)
        key_pool.push_back(oaht_pkg::KeyW'($urandom_range(0, 1000) * n
                                           + $urandom_range(0, (n - 1) / 4)));
      else
        key_pool.push_back(oaht_pkg::KeyW'($urandom()));
    end
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      op = oaht_pkg::FuncInsert;
      else if (pick < 70) op = oaht_pkg::FuncRemove;
      else if (pick < 95) op = oaht_pkg::FuncLookup;
      else                op = FuncSpare;
      if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else                          key = oaht_pkg::KeyW'($urandom());
      send_op(op, key);
    end
  endtask

  task automatic test_random_traffic();
    logic [oaht_pkg::NumW-1:0] phase_sizes [14] = '{9'd2, 9'd5, 9'd16, 9'd1, 9'd37, 9'd8,
                                                    9'd256, 9'd64, 9'd3, 9'd511, 9'd100,
                                                    9'd0, 9'd13, 9'd255};
    foreach (phase_sizes[i])
      run_random_phase(phase_sizes[i], (effective_slots(phase_sizes[i]) >= 200) ? 60 : 135);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    probe_result_t want;
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("unexpected result: status %0d slot %0d", status, slot);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || slot !== want.slot) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("result mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     want.status, want.slot, status, slot);
        end
      end
    end
    rx_cycle++;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(64, 256);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RxAlways: begin
        out_ready <= 1'b1;
      end
      RxCoin: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      RxSparse: begin
        out_ready <= (rx_cycle % 8 == 0);
      end
      default: begin
        out_ready <= (rx_cycle % 32 >= 28);
      end
    endcase
  end

  // The run is stopped if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("[open_addressing_hash_table_unit] ERROR");
      $finish;
    end
  end

  initial begin
    foreach (slot_used[i]) begin
      slot_used[i]  = 1'b0;
      slot_key_q[i] = '0;
    end
    table_size_q = oaht_pkg::TableSizeReset;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_collision_and_wrap();
    test_size_extremes();
    test_full_circle();
    test_random_traffic();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[open_addressing_hash_table_unit] OK");
    end else begin
      $display("[open_addressing_hash_table_unit] ERROR");
    end
    $finish;
  end

endmodule
